// ===== sv/mkb_pkg.sv =====
// Shared constants and control types for the masked Kyber base multiplier.
package mkb_pkg;

  localparam int KYBER_Q       = 3329;
  localparam int QINV          = -3327;
  localparam int TWIDDLE_RESET = -1044;
  localparam int HALF_BITS     = 16;
  localparam int COEF_W        = 16;
  localparam int ACC_W         = 32;
  localparam int TWIDDLE_W     = 12;
  localparam int MASK_PAIR_W   = 32;
  localparam int NUM_STAGES    = 7;

  // Load enables for a two-stage section of the pipeline.
  typedef struct packed {
    logic first;
    logic second;
  } mkb_en2_t;

endpackage

// ===== sv/mkb_ifs.sv =====
// Handshake channel interfaces for input, result and configuration transactions.
interface mkb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mkb_pkg::COEF_W-1:0]     share0_lo;
  logic signed [mkb_pkg::COEF_W-1:0]     share0_hi;
  logic signed [mkb_pkg::COEF_W-1:0]     share1_lo;
  logic signed [mkb_pkg::COEF_W-1:0]     share1_hi;
  logic signed [mkb_pkg::COEF_W-1:0]     operand_lo;
  logic signed [mkb_pkg::COEF_W-1:0]     operand_hi;
  logic        [mkb_pkg::MASK_PAIR_W-1:0] mask_pair_a;
  logic        [mkb_pkg::MASK_PAIR_W-1:0] mask_pair_b;
  logic        [mkb_pkg::MASK_PAIR_W-1:0] mask_pair_c;
  logic        [mkb_pkg::MASK_PAIR_W-1:0] mask_pair_d;

  modport source (output valid, share0_lo, share0_hi, share1_lo, share1_hi,
                  operand_lo, operand_hi, mask_pair_a, mask_pair_b,
                  mask_pair_c, mask_pair_d, input ready);
  modport sink   (input valid, share0_lo, share0_hi, share1_lo, share1_hi,
                  operand_lo, operand_hi, mask_pair_a, mask_pair_b,
                  mask_pair_c, mask_pair_d, output ready);
endinterface

interface mkb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mkb_pkg::COEF_W-1:0] out_share0_lo;
  logic signed [mkb_pkg::COEF_W-1:0] out_share1_lo;
  logic signed [mkb_pkg::COEF_W-1:0] out_share0_hi;
  logic signed [mkb_pkg::COEF_W-1:0] out_share1_hi;

  modport source (output valid, out_share0_lo, out_share1_lo, out_share0_hi,
                  out_share1_hi, input ready);
  modport sink   (input valid, out_share0_lo, out_share1_lo, out_share0_hi,
                  out_share1_hi, output ready);
endinterface

interface mkb_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mkb_pkg::TWIDDLE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/mkb_mask_prod.sv =====
// Two-stage mask refresh unit: mask products and their pairwise sums.
module mkb_mask_prod (
  input  logic                                  clk,
  input  mkb_pkg::mkb_en2_t                     en,
  input  logic [mkb_pkg::MASK_PAIR_W-1:0]       pair_a,
  input  logic [mkb_pkg::MASK_PAIR_W-1:0]       pair_b,
  input  logic [mkb_pkg::MASK_PAIR_W-1:0]       pair_c,
  input  logic [mkb_pkg::MASK_PAIR_W-1:0]       pair_d,
  output logic [mkb_pkg::ACC_W-1:0]             lo_pos,
  output logic [mkb_pkg::ACC_W-1:0]             lo_neg,
  output logic [mkb_pkg::ACC_W-1:0]             hi_pos,
  output logic [mkb_pkg::ACC_W-1:0]             hi_neg
);

  localparam int CW = mkb_pkg::COEF_W;
  localparam int AW = mkb_pkg::ACC_W;

  logic signed [CW-1:0] r0, r1, r2, r3, r4, r5, r6, r7;
  logic signed [CW-1:0] nr0, nr2, nr4, nr6;

  logic [AW-1:0] m01_r, n01_r, m23_r, n23_r, m45_r, n45_r, m67_r, n67_r;
  logic [AW-1:0] m01_nxt, n01_nxt, m23_nxt, n23_nxt;
  logic [AW-1:0] m45_nxt, n45_nxt, m67_nxt, n67_nxt;
  logic [AW-1:0] lo_pos_r, lo_neg_r, hi_pos_r, hi_neg_r;

  always_comb begin
    r0 = pair_a[CW-1:0];
    r1 = pair_a[2*CW-1:CW];
    r2 = pair_b[CW-1:0];
    r3 = pair_b[2*CW-1:CW];
    r4 = pair_c[CW-1:0];
    r5 = pair_c[2*CW-1:CW];
    r6 = pair_d[CW-1:0];
    r7 = pair_d[2*CW-1:CW];
    // Negation wraps at 16 bits, so the most negative mask stays as it is.
    nr0 = CW'(-r0);
    nr2 = CW'(-r2);
    nr4 = CW'(-r4);
    nr6 = CW'(-r6);
    m01_nxt = AW'(r0 * r1);
    n01_nxt = AW'(nr0 * r1);
    m23_nxt = AW'(r2 * r3);
    n23_nxt = AW'(nr2 * r3);
    m45_nxt = AW'(r4 * r5);
    n45_nxt = AW'(nr4 * r5);
    m67_nxt = AW'(r6 * r7);
    n67_nxt = AW'(nr6 * r7);
  end

  always_ff @(posedge clk) begin
    if (en.first) begin
      m01_r <= m01_nxt;
      n01_r <= n01_nxt;
      m23_r <= m23_nxt;
      n23_r <= n23_nxt;
      m45_r <= m45_nxt;
      n45_r <= n45_nxt;
      m67_r <= m67_nxt;
      n67_r <= n67_nxt;
    end
    if (en.second) begin
      lo_pos_r <= m01_r + m23_r;
      lo_neg_r <= n01_r + n23_r;
      hi_pos_r <= m45_r + m67_r;
      hi_neg_r <= n45_r + n67_r;
    end
  end

  assign lo_pos = lo_pos_r;
  assign lo_neg = lo_neg_r;
  assign hi_pos = hi_pos_r;
  assign hi_neg = hi_neg_r;

endmodule

// ===== sv/mkb_mred.sv =====
// Two-stage Montgomery reducer over a number of parallel lanes.
module mkb_mred #(
  parameter int LANES = 1
) (
  input  logic                                    clk,
  input  mkb_pkg::mkb_en2_t                       en,
  input  logic [LANES-1:0][mkb_pkg::ACC_W-1:0]    x_i,
  output logic [LANES-1:0][mkb_pkg::COEF_W-1:0]   y_o
);

  localparam int CW = mkb_pkg::COEF_W;
  localparam int AW = mkb_pkg::ACC_W;
  localparam logic [CW-1:0]        QINV16 = CW'(mkb_pkg::QINV);
  localparam logic signed [12:0]   Q13    = 13'(mkb_pkg::KYBER_Q);

  logic [LANES-1:0][AW-1:0] x_r;
  logic [LANES-1:0][CW-1:0] t_r, t_nxt;
  logic [LANES-1:0][CW-1:0] y_r, y_nxt;
  logic signed [AW-1:0]     tq [LANES];
  logic [AW-1:0]            d  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Only the low half of x times q^-1 matters for t.
      t_nxt[l] = CW'(x_i[l][CW-1:0] * QINV16);
      tq[l]    = $signed(t_r[l]) * Q13;
      d[l]     = x_r[l] - AW'(tq[l]);
      y_nxt[l] = d[l][AW-1:mkb_pkg::HALF_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en.first) begin
      x_r <= x_i;
      t_r <= t_nxt;
    end
    if (en.second) begin
      y_r <= y_nxt;
    end
  end

  assign y_o = y_r;

endmodule

// ===== sv/masked_kyber_basemul_unit.sv =====
// Top level of the masked Kyber NTT base multiplier with Montgomery reduction.
//
// Usage: one transaction on in_ch carries two arithmetic shares of a degree-one
// polynomial, a plain operand pair and four mask pairs. Exactly one result
// transaction on out_ch follows for each input, in order, holding the two
// refreshed output shares of the low and the high product coefficient.
// The cfg_ch channel writes the signed 12-bit twiddle factor; it is always
// ready and must only be written while the pipeline holds no transaction.
// The result of an input transaction becomes valid on out_ch once it has passed
// through all pipeline stages. A new input transaction is accepted in every
// cycle in which the pipeline has room, so the sustained rate is one item per
// clock while the receiver takes results; it is set by the seven-stage pipeline
// of registered multipliers, adders and the two Montgomery reducers.
// Each stage carries its own valid bit and has a local ready, so bubbles are
// squeezed out: while the receiver stalls, input is still taken until every
// stage holds an item, and then in_ch.ready drops. Nothing is lost or repeated.
// A synchronous active-low reset empties the pipeline and restores the
// twiddle to its Montgomery-domain default of -1044.
module masked_kyber_basemul_unit (
  input  logic      clk,
  input  logic      rst_n,
  mkb_in_if.sink    in_ch,
  mkb_out_if.source out_ch,
  mkb_cfg_if.sink   cfg_ch
);

  localparam int CW = mkb_pkg::COEF_W;
  localparam int AW = mkb_pkg::ACC_W;
  localparam int NS = mkb_pkg::NUM_STAGES;

  // Stage valid bits and the ready chain; rdy[k] loads stage k.
  logic [NS:1]   v_r;
  logic [NS:1]   v_nxt;
  logic [NS+1:1] rdy;

  logic signed [mkb_pkg::TWIDDLE_W-1:0] twiddle_r;

  // Stage 1: the twiddle product and the plain data products.
  logic [AW-1:0]        pz_r, pd_lo0_r, pd_lo1_r;
  logic [AW-1:0]        pd_hi0a_r, pd_hi0b_r, pd_hi1a_r, pd_hi1b_r;
  logic signed [CW-1:0] s0hi_r1, s1hi_r1;

  // Stage 2: data sums of the high coefficients; the low products pass through.
  logic [AW-1:0]        sd_lo0_r, sd_lo1_r, sd_hi0_r, sd_hi1_r;
  logic signed [CW-1:0] s0hi_r2, s1hi_r2;

  // Stage 3: data plus mask refresh.
  logic [AW-1:0]        part_lo0_r, part_lo1_r, part_hi0_r, part_hi1_r;
  logic signed [CW-1:0] s0hi_r3, s1hi_r3;

  // Stage 4: products with the reduced twiddle term.
  logic [AW-1:0]        zp0_r, zp1_r, part_lo0_r4, part_lo1_r4, part_hi0_r4, part_hi1_r4;

  // Stage 5: full accumulators, ready for reduction.
  logic [AW-1:0]        acc_lo0_r, acc_lo1_r, acc_hi0_r, acc_hi1_r;

  logic [AW-1:0] mlo_pos, mlo_neg, mhi_pos, mhi_neg;
  logic [0:0][CW-1:0] zb;
  logic [3:0][AW-1:0] acc_vec;
  logic [3:0][CW-1:0] res_vec;

  mkb_pkg::mkb_en2_t mask_en, zred_en, fred_en;

  always_comb begin
    rdy[NS+1] = out_ch.ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[1] = rdy[1] ? in_ch.valid : v_r[1];
    for (int k = 2; k <= NS; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_ch.ready  = rdy[1];
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      twiddle_r <= mkb_pkg::TWIDDLE_W'(mkb_pkg::TWIDDLE_RESET);
    end else begin
      v_r <= v_nxt;
      if (cfg_ch.valid) begin
        twiddle_r <= cfg_ch.data;
      end
    end
  end

  // Datapath registers move whenever their stage is free to load.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pz_r      <= AW'(in_ch.operand_hi * twiddle_r);
      pd_lo0_r  <= AW'(in_ch.share0_lo * in_ch.operand_lo);
      pd_lo1_r  <= AW'(in_ch.share1_lo * in_ch.operand_lo);
      pd_hi0a_r <= AW'(in_ch.share0_lo * in_ch.operand_hi);
      pd_hi0b_r <= AW'(in_ch.share0_hi * in_ch.operand_lo);
      pd_hi1a_r <= AW'(in_ch.share1_lo * in_ch.operand_hi);
      pd_hi1b_r <= AW'(in_ch.share1_hi * in_ch.operand_lo);
      s0hi_r1   <= in_ch.share0_hi;
      s1hi_r1   <= in_ch.share1_hi;
    end
    if (rdy[2]) begin
      sd_lo0_r <= pd_lo0_r;
      sd_lo1_r <= pd_lo1_r;
      sd_hi0_r <= pd_hi0a_r + pd_hi0b_r;
      sd_hi1_r <= pd_hi1a_r + pd_hi1b_r;
      s0hi_r2  <= s0hi_r1;
      s1hi_r2  <= s1hi_r1;
    end
    if (rdy[3]) begin
      part_lo0_r <= sd_lo0_r + mlo_pos;
      part_lo1_r <= sd_lo1_r + mlo_neg;
      part_hi0_r <= sd_hi0_r + mhi_pos;
      part_hi1_r <= sd_hi1_r + mhi_neg;
      s0hi_r3    <= s0hi_r2;
      s1hi_r3    <= s1hi_r2;
    end
    if (rdy[4]) begin
      zp0_r       <= AW'(s0hi_r3 * $signed(zb[0]));
      zp1_r       <= AW'(s1hi_r3 * $signed(zb[0]));
      part_lo0_r4 <= part_lo0_r;
      part_lo1_r4 <= part_lo1_r;
      part_hi0_r4 <= part_hi0_r;
      part_hi1_r4 <= part_hi1_r;
    end
    if (rdy[5]) begin
      acc_lo0_r <= part_lo0_r4 + zp0_r;
      acc_lo1_r <= part_lo1_r4 + zp1_r;
      acc_hi0_r <= part_hi0_r4;
      acc_hi1_r <= part_hi1_r4;
    end
  end

  // The mask unit runs alongside stages 1 and 2.
  assign mask_en.first  = rdy[1];
  assign mask_en.second = rdy[2];

  mkb_mask_prod u_mask (
    .clk    (clk),
    .en     (mask_en),
    .pair_a (in_ch.mask_pair_a),
    .pair_b (in_ch.mask_pair_b),
    .pair_c (in_ch.mask_pair_c),
    .pair_d (in_ch.mask_pair_d),
    .lo_pos (mlo_pos),
    .lo_neg (mlo_neg),
    .hi_pos (mhi_pos),
    .hi_neg (mhi_neg)
  );

  // The reduced twiddle product zb is ready at the end of stage 3.
  assign zred_en.first  = rdy[2];
  assign zred_en.second = rdy[3];

  mkb_mred #(.LANES(1)) u_zred (
    .clk (clk),
    .en  (zred_en),
    .x_i (pz_r),
    .y_o (zb)
  );

  // Final reduction of all four accumulators in stages 6 and 7; its output
  // registers are the result channel's payload.
  assign fred_en.first  = rdy[6];
  assign fred_en.second = rdy[7];
  assign acc_vec = {acc_hi1_r, acc_hi0_r, acc_lo1_r, acc_lo0_r};

  mkb_mred #(.LANES(4)) u_fred (
    .clk (clk),
    .en  (fred_en),
    .x_i (acc_vec),
    .y_o (res_vec)
  );

  assign out_ch.out_share0_lo = res_vec[0];
  assign out_ch.out_share1_lo = res_vec[1];
  assign out_ch.out_share0_hi = res_vec[2];
  assign out_ch.out_share1_hi = res_vec[3];

  // Input back-pressure only appears when every stage is full and the
  // receiver is stalling.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_r == '1 && !out_ch.ready))
    else $error("input blocked while the pipeline has room");

  // An item entering an empty pipeline comes out after the full latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && v_r == '0) |-> ##NS out_ch.valid)
    else $error("result missing after pipeline latency");

  // A configuration write lands in the twiddle register.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready) |=> (twiddle_r == $past(cfg_ch.data)))
    else $error("twiddle write lost");

endmodule

// ===== test/masked_kyber_basemul_unit_test.sv =====
// Self-checking testbench for the masked Kyber NTT base multiplier with Montgomery reduction.
module masked_kyber_basemul_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = mkb_pkg::COEF_W;
  localparam int AW = mkb_pkg::ACC_W;
  localparam int MW = mkb_pkg::MASK_PAIR_W;
  localparam int TW = mkb_pkg::TWIDDLE_W;

  // One input transaction: two shares, the plain operand and the four mask pairs.
  typedef struct {
    logic signed [CW-1:0] share0_lo;
    logic signed [CW-1:0] share0_hi;
    logic signed [CW-1:0] share1_lo;
    logic signed [CW-1:0] share1_hi;
    logic signed [CW-1:0] operand_lo;
    logic signed [CW-1:0] operand_hi;
    logic        [MW-1:0] mask_pair_a;
    logic        [MW-1:0] mask_pair_b;
    logic        [MW-1:0] mask_pair_c;
    logic        [MW-1:0] mask_pair_d;
  } basemul_operands_t;

  // One result transaction: the refreshed shares of both product coefficients.
  typedef struct {
    logic signed [CW-1:0] share0_lo;
    logic signed [CW-1:0] share1_lo;
    logic signed [CW-1:0] share0_hi;
    logic signed [CW-1:0] share1_hi;
  } basemul_shares_t;

  // The tracker keeps its own copy of the twiddle, works out the refreshed
  // product shares of each accepted input and holds them until the matching
  // result transaction arrives.
  class basemul_share_tracker;
    logic signed [TW-1:0] twiddle;
    basemul_shares_t      pending_shares[$];
    int                   errors;
    int                   matched;

    function new();
      twiddle = TW'(mkb_pkg::TWIDDLE_RESET);
      errors  = 0;
      matched = 0;
    endfunction

    function void set_twiddle(logic signed [TW-1:0] value);
      twiddle = value;
    endfunction

    function int pending();
      return pending_shares.size();
    endfunction

    // Signed product of two small values, kept modulo 2^32.
    function logic [AW-1:0] wide_mul(int a, int b);
      return a * b;
    endfunction

    // Montgomery reduction of a 32-bit accumulator with R = 2^16.
    function logic signed [CW-1:0] mont_reduce(logic [AW-1:0] acc);
      logic [AW-1:0]        lowprod;
      logic signed [CW-1:0] t;
      logic [AW-1:0]        diff;
      lowprod = acc * AW'(mkb_pkg::QINV);
      t       = lowprod[CW-1:0];
      diff    = acc - AW'(int'(t) * mkb_pkg::KYBER_Q);
      return diff[AW-1:mkb_pkg::HALF_BITS];
    endfunction

    function basemul_shares_t predict_shares(basemul_operands_t op);
      logic signed [CW-1:0] r0, r1, r2, r3, r4, r5, r6, r7;
      logic signed [CW-1:0] n0, n2, n4, n6;
      logic signed [CW-1:0] zb;
      logic [AW-1:0]        acc;
      basemul_shares_t      res;
      {r1, r0} = op.mask_pair_a;
      {r3, r2} = op.mask_pair_b;
      {r5, r4} = op.mask_pair_c;
      {r7, r6} = op.mask_pair_d;
      // Negation stays in 16 bits, so the most negative mask maps to itself.
      n0 = -r0;
      n2 = -r2;
      n4 = -r4;
      n6 = -r6;
      zb = mont_reduce(wide_mul(op.operand_hi, twiddle));
      acc = wide_mul(op.share0_lo, op.operand_lo) + wide_mul(r0, r1)
          + wide_mul(op.share0_hi, zb) + wide_mul(r2, r3);
      res.share0_lo = mont_reduce(acc);
      acc = wide_mul(op.share1_lo, op.operand_lo) + wide_mul(n0, r1)
          + wide_mul(op.share1_hi, zb) + wide_mul(n2, r3);
      res.share1_lo = mont_reduce(acc);
      acc = wide_mul(op.share0_lo, op.operand_hi) + wide_mul(r4, r5)
          + wide_mul(op.share0_hi, op.operand_lo) + wide_mul(r6, r7);
      res.share0_hi = mont_reduce(acc);
      acc = wide_mul(op.share1_lo, op.operand_hi) + wide_mul(n4, r5)
          + wide_mul(op.share1_hi, op.operand_lo) + wide_mul(n6, r7);
      res.share1_hi = mont_reduce(acc);
      return res;
    endfunction

    function void note_input(basemul_operands_t op);
      pending_shares.push_back(predict_shares(op));
    endfunction

    function void compare_field(string name, logic signed [CW-1:0] want,
                                logic signed [CW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(basemul_shares_t got);
      basemul_shares_t want;
      if (pending_shares.size() == 0) begin
        errors++;
        $display("%0t: result transaction with no pending input, actual %0d %0d %0d %0d",
                 $time, got.share0_lo, got.share1_lo, got.share0_hi, got.share1_hi);
        return;
      end
      want = pending_shares.pop_front();
      compare_field("out_share0_lo", want.share0_lo, got.share0_lo);
      compare_field("out_share1_lo", want.share1_lo, got.share1_lo);
      compare_field("out_share0_hi", want.share0_hi, got.share0_hi);
      compare_field("out_share1_hi", want.share1_hi, got.share1_hi);
      matched++;
    endfunction
  endclass

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 318;
  localparam int DRAIN_CYCLES     = mkb_pkg::NUM_STAGES + 3;

  logic clk;
  logic rst_n;

  mkb_in_if  in_ch();
  mkb_out_if out_ch();
  mkb_cfg_if cfg_ch();

  masked_kyber_basemul_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  basemul_share_tracker tracker;

  // Idle rates in percent, changed by the main sequence between phases.
  int sender_idle_pct;
  int receiver_stall_pct;
  int inputs_sent;
  int twiddle_writes;

  // The clock starts low, so the first rising edge comes half a period in.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: far beyond the slowest correct run, even with every result
  // waiting out the receiver's stalls and every input the sender's gaps.
  initial begin
    #2_000_000;
    $display("masked_kyber_basemul_unit test failed");
    $finish;
  end

  // Result side. Outputs are sampled at the rising edge, and ready is changed
  // at the falling edge only, so there is no race with the block's registers.
  initial begin
    basemul_shares_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.share0_lo = out_ch.out_share0_lo;
        got.share1_lo = out_ch.out_share1_lo;
        got.share0_hi = out_ch.out_share0_hi;
        got.share1_hi = out_ch.out_share1_hi;
        tracker.check_result(got);
      end
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Sends one input transaction. It is called at a falling edge and returns at
  // a falling edge, so valid sees at most one assignment per time step: a held
  // valid is simply driven high again for the next item.
  task automatic send_operands(basemul_operands_t op);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.share0_lo   <= op.share0_lo;
    in_ch.share0_hi   <= op.share0_hi;
    in_ch.share1_lo   <= op.share1_lo;
    in_ch.share1_hi   <= op.share1_hi;
    in_ch.operand_lo  <= op.operand_lo;
    in_ch.operand_hi  <= op.operand_hi;
    in_ch.mask_pair_a <= op.mask_pair_a;
    in_ch.mask_pair_b <= op.mask_pair_b;
    in_ch.mask_pair_c <= op.mask_pair_c;
    in_ch.mask_pair_d <= op.mask_pair_d;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    // The transaction has been accepted at this edge.
    tracker.note_input(op);
    inputs_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(logic signed [CW-1:0] s0lo, logic signed [CW-1:0] s0hi,
                             logic signed [CW-1:0] s1lo, logic signed [CW-1:0] s1hi,
                             logic signed [CW-1:0] b0, logic signed [CW-1:0] b1,
                             logic [MW-1:0] ma, logic [MW-1:0] mb,
                             logic [MW-1:0] mc, logic [MW-1:0] md);
    basemul_operands_t op;
    op.share0_lo   = s0lo;
    op.share0_hi   = s0hi;
    op.share1_lo   = s1lo;
    op.share1_hi   = s1hi;
    op.operand_lo  = b0;
    op.operand_hi  = b1;
    op.mask_pair_a = ma;
    op.mask_pair_b = mb;
    op.mask_pair_c = mc;
    op.mask_pair_d = md;
    send_operands(op);
  endtask

  // Stops sending, waits until every expected result has arrived, then lets
  // the pipeline settle for a little longer than its depth.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the twiddle register; only called while the pipeline is empty.
  task automatic write_twiddle(logic signed [TW-1:0] value);
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_twiddle(value);
    twiddle_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random coefficients lean toward the extremes now and then, since those are
  // where the 32-bit accumulators wrap.
  function automatic logic signed [CW-1:0] pick_coef();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic basemul_operands_t pick_operands();
    basemul_operands_t op;
    op.share0_lo   = pick_coef();
    op.share0_hi   = pick_coef();
    op.share1_lo   = pick_coef();
    op.share1_hi   = pick_coef();
    op.operand_lo  = pick_coef();
    op.operand_hi  = pick_coef();
    op.mask_pair_a = {pick_coef(), pick_coef()};
    op.mask_pair_b = {pick_coef(), pick_coef()};
    op.mask_pair_c = {pick_coef(), pick_coef()};
    op.mask_pair_d = {pick_coef(), pick_coef()};
    return op;
  endfunction

  // Main sequence: reset, a directed set at the reset twiddle, then random
  // phases, each with a new twiddle written while the pipeline is empty.
  initial begin
    logic signed [TW-1:0] phase_twiddle[RANDOM_PHASES];

    tracker            = new();
    sender_idle_pct    = 6;
    receiver_stall_pct = 58;
    inputs_sent        = 0;
    twiddle_writes     = 0;

    // Every input of the block is known from time zero.
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.share0_lo    = '0;
    in_ch.share0_hi    = '0;
    in_ch.share1_lo    = '0;
    in_ch.share1_hi    = '0;
    in_ch.operand_lo   = '0;
    in_ch.operand_hi   = '0;
    in_ch.mask_pair_a  = '0;
    in_ch.mask_pair_b  = '0;
    in_ch.mask_pair_c  = '0;
    in_ch.mask_pair_d  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, still at the reset twiddle of -1044.
    send_fields(0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF);
    // All coefficients most negative: the accumulators wrap past 2^32, and
    // every mask is the one that negates to itself.
    send_fields(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000);
    send_fields(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                32'h80007FFF, 32'h7FFF8000, 32'h80007FFF, 32'h7FFF8000);
    send_fields(1, 1, 1, 1, 1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_fields(1, 0, 0, 0, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(0, 1, 0, 1, 0, 1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(0, 16'sh7FFF, 0, 16'sh8000, 0, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(0, 0, 0, 0, 0, 0, 32'h7FFF8000, 32'h0, 32'h0, 32'h0);
    send_fields(0, 0, 0, 0, 0, 0, 32'h0, 32'h80008000, 32'h0, 32'h0);
    send_fields(0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h7FFF8000, 32'h80008000);
    send_fields(3329, -3329, 3328, -3328, 3329, -3329,
                32'h0D010D01, 32'hF2FFF2FF, 32'h00010D01, 32'h0D010001);
    send_fields(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                32'h00010001, 32'hFFFF0001, 32'h0001FFFF, 32'hFFFFFFFF);
    send_fields(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA,
                32'h5555AAAA, 32'hAAAA5555, 32'h5555AAAA, 32'hAAAA5555);
    send_fields(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                32'h7FFF7FFF, 32'h7FFF7FFF, 32'h80008000, 32'h80008000);
    send_fields(1664, -1664, 1664, -1664, -1664, 1664,
                32'h06800680, 32'hF980F980, 32'h0680F980, 32'hF9800680);
    drain_pipeline();

    // Twiddle settings per phase: both ends of the intended range, both ends
    // of the 12-bit field, zero and one random value.
    phase_twiddle[0] = -12'sd1664;
    phase_twiddle[1] = 12'sd1664;
    phase_twiddle[2] = 12'sh7FF;
    phase_twiddle[3] = 12'sh800;
    phase_twiddle[4] = 12'sd0;
    phase_twiddle[5] = TW'($urandom_range(4095));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Two phases with a slow receiver, two with a slow sender, two without
      // idling on either side.
      if (phase < 2) begin
        sender_idle_pct    = 6;
        receiver_stall_pct = 58;
      end else if (phase < 4) begin
        sender_idle_pct    = 58;
        receiver_stall_pct = 6;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      write_twiddle(phase_twiddle[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Midway through one phase the sender holds off until the pipeline
        // has handed out every result.
        if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_ch.valid <= 1'b0;
          @(negedge clk);
          while (tracker.pending() != 0) @(negedge clk);
        end
        send_operands(pick_operands());
      end
      drain_pipeline();
    end

    // Give the block a last chance to emit anything unexpected.
    repeat (4 * mkb_pkg::NUM_STAGES) @(negedge clk);

    $display("Sent %0d input transactions and checked %0d results over %0d twiddle writes,",
             inputs_sent, tracker.matched, twiddle_writes);
    $display("with the sender and the receiver stalling in turn and a stretch at full rate.");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("masked_kyber_basemul_unit test passed");
    end else begin
      $display("masked_kyber_basemul_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mkb_pkg.sv
sv/mkb_ifs.sv
sv/mkb_mask_prod.sv
sv/mkb_mred.sv
sv/masked_kyber_basemul_unit.sv
test/masked_kyber_basemul_unit_test.sv
